### hw/rtl/bcfs_pkg.sv
// ---------------------------------------------------------------------------
// bcfs_pkg
// Shared constants, types and the delta tile function for the tile frame
// stream decoder.
// ---------------------------------------------------------------------------
package bcfs_pkg;

  localparam int TILE_COUNT_DEF = 1000;

  localparam logic [15:0] FRAME_LIMIT_RST = 16'd6570;

  // input word kinds
  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // result word kinds
  localparam logic RES_RUN  = 1'b0;
  localparam logic RES_READ = 1'b1;

  // varint handling
  localparam logic [5:0]  SHIFT_STEP = 6'd7;
  localparam logic [5:0]  SHIFT_MAX  = 6'd28;
  localparam logic [4:0]  SHIFT_SAT  = 5'd16;
  localparam logic [15:0] COUNT_MAX  = 16'hffff;

  // angle increment per d[5:3]: 0, -1, +1, +8, -3, +3, -5, +5 (mod 16)
  localparam logic [3:0] ANGLE_STEP [8] = '{4'd0, 4'd15, 4'd1, 4'd8,
                                            4'd13, 4'd3, 4'd11, 4'd5};

  typedef struct packed {
    logic take;
    logic restart;
    logic parse;
    logic rd_issue;
    logic rd_cap;
    logic fin;
    logic key_wr;
    logic delta_rd;
    logic delta_wr;
    logic emit;
  } bcfs_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       active;
    logic       run_done;
    logic       walk_go;
    logic       walk_key;
    logic       walk_last;
    logic       out_free;
  } bcfs_status_t;

  function automatic logic [7:0] delta_tile(logic [7:0] t, logic [6:0] d);
    logic [2:0] pw;
    logic [3:0] an;
    logic       ds;
    pw = t[2:0] - d[2:0];
    an = t[6:3] + ANGLE_STEP[d[5:3]];
    ds = t[7] ^ d[6];
    return {ds, an, pw};
  endfunction

endpackage

### hw/rtl/bcfs_ctrl.sv
// ---------------------------------------------------------------------------
// bcfs_ctrl
// Sequencer for the tile frame stream decoder: takes one word, steps the
// parser, walks the tile table for a run and hands the result to the output.
// ---------------------------------------------------------------------------
module bcfs_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  bcfs_pkg::bcfs_status_t st,
  output bcfs_pkg::bcfs_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_KWALK  = 3'd4;
  localparam logic [2:0] S_DRD    = 3'd5;
  localparam logic [2:0] S_DWR    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (st.kind)
          bcfs_pkg::KIND_READ: begin
            cmd.rd_issue = 1'b1;
            state_nxt    = S_RDWAIT;
          end
          bcfs_pkg::KIND_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt   = S_IDLE;
          end
          bcfs_pkg::KIND_BYTE: begin
            cmd.parse = st.active;
            state_nxt = (st.active && st.run_done) ? S_FIN : S_IDLE;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RDWAIT: begin
        cmd.rd_cap = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (!st.walk_go) state_nxt = S_EMIT;
        else if (st.walk_key) state_nxt = S_KWALK;
        else state_nxt = S_DRD;
      end
      S_KWALK: begin
        cmd.key_wr = 1'b1;
        if (st.walk_last) state_nxt = S_EMIT;
      end
      S_DRD: begin
        cmd.delta_rd = 1'b1;
        state_nxt    = S_DWR;
      end
      S_DWR: begin
        cmd.delta_wr = 1'b1;
        state_nxt    = st.walk_last ? S_EMIT : S_DRD;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### hw/rtl/bcfs_dp.sv
// ---------------------------------------------------------------------------
// bcfs_dp
// Datapath of the tile frame stream decoder: varint parser, frame and tile
// position counters, tile table memory, run walker and output register.
// ---------------------------------------------------------------------------
module bcfs_dp #(
  parameter int TILE_COUNT = bcfs_pkg::TILE_COUNT_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  input  logic [23:0]            in_tdata,
  input  logic [1:0]             in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  bcfs_pkg::bcfs_cmd_t    cmd,
  output bcfs_pkg::bcfs_status_t st
);

  localparam int         AW = (TILE_COUNT > 1) ? $clog2(TILE_COUNT) : 1;
  localparam logic [10:0] TC = 11'(TILE_COUNT);

  // latched input word
  logic [1:0]  kind_r;
  logic [7:0]  byte_r;
  logic [9:0]  idx_r;

  // decoder state
  logic [15:0] limit_r;
  logic [15:0] fc_r;
  logic [10:0] pos_r;
  logic        phase_r;
  logic [7:0]  held_r;
  logic [15:0] acc_r;
  logic [4:0]  shift_r;
  logic [7:0]  run_code_r;
  logic [10:0] fill_r;

  // run walker
  logic [10:0] walk_ptr_r;
  logic [10:0] walk_left_r;

  // pending result
  logic        rec_kind_r;
  logic [9:0]  rec_first_r;
  logic [10:0] rec_len_r;
  logic [7:0]  rec_code_r;
  logic        rec_key_r;
  logic        rec_end_r;
  logic [15:0] rec_fn_r;

  // output register
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [1:0]  out_user_r;
  logic        out_last_r;

  // tile table
  logic [7:0]    mem [TILE_COUNT];
  logic [7:0]    rdata_r;
  logic [AW-1:0] raddr;
  logic [7:0]    old_tile;
  logic [7:0]    wdata;
  logic          mem_we;

  logic        key_now;
  logic [21:0] chunk_sh;
  logic [22:0] acc_sum;
  logic [15:0] acc_nxt;
  logic [5:0]  shift_add;
  logic [4:0]  shift_nxt;
  logic [16:0] count;
  logic [10:0] left;
  logic [10:0] len;
  logic [10:0] pos_sum;
  logic        run_end;
  logic        out_free;

  assign key_now = (fc_r == 16'd0);

  // varint accumulate with saturation
  always_comb begin
    chunk_sh  = 22'(byte_r[6:0]) << shift_r[3:0];
    acc_sum   = 23'(acc_r) + 23'(chunk_sh);
    if (byte_r[6:0] == 7'd0) acc_nxt = acc_r;
    else if (shift_r >= bcfs_pkg::SHIFT_SAT) acc_nxt = bcfs_pkg::COUNT_MAX;
    else if (acc_sum[22:16] != 7'd0) acc_nxt = bcfs_pkg::COUNT_MAX;
    else acc_nxt = acc_sum[15:0];
    shift_add = 6'(shift_r) + bcfs_pkg::SHIFT_STEP;
    shift_nxt = (shift_add > bcfs_pkg::SHIFT_MAX) ? bcfs_pkg::SHIFT_MAX[4:0]
                                                  : shift_add[4:0];
  end

  // run clamp at the end of the table
  always_comb begin
    count   = 17'(acc_r) + 17'(!key_now);
    left    = TC - pos_r;
    len     = (count < 17'(left)) ? count[10:0] : left;
    pos_sum = pos_r + len;
    run_end = (pos_sum >= TC);
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    st.kind      = kind_r;
    st.active    = (fc_r < limit_r);
    st.run_done  = phase_r ? !byte_r[7] : (!key_now && !byte_r[7]);
    st.walk_go   = (len != 11'd0) && (key_now || (run_code_r != 8'd0));
    st.walk_key  = key_now;
    st.walk_last = (walk_left_r == 11'd1);
    st.out_free  = out_free;
  end

  // tile table access; entries at or above the fill count read as zero
  assign raddr    = cmd.delta_rd ? walk_ptr_r[AW-1:0] : idx_r[AW-1:0];
  assign old_tile = (walk_ptr_r < fill_r) ? rdata_r : 8'h00;
  assign wdata    = cmd.key_wr ? run_code_r
                               : bcfs_pkg::delta_tile(old_tile, run_code_r[6:0]);
  assign mem_we   = cmd.key_wr || cmd.delta_wr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[walk_ptr_r[AW-1:0]] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      kind_r <= in_tuser;
      byte_r <= in_tdata[7:0];
      idx_r  <= in_tdata[17:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= bcfs_pkg::FRAME_LIMIT_RST;
      fc_r       <= '0;
      pos_r      <= '0;
      phase_r    <= 1'b0;
      held_r     <= '0;
      acc_r      <= '0;
      shift_r    <= '0;
      run_code_r <= '0;
      fill_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.restart) begin
        fc_r    <= '0;
        pos_r   <= '0;
        phase_r <= 1'b0;
        held_r  <= '0;
        acc_r   <= '0;
        shift_r <= '0;
      end
      if (cmd.parse) begin
        if (phase_r) begin
          acc_r <= acc_nxt;
          if (byte_r[7]) shift_r <= shift_nxt;
          run_code_r <= key_now ? held_r : {1'b0, held_r[6:0]};
        end else if (key_now || byte_r[7]) begin
          held_r  <= byte_r;
          acc_r   <= '0;
          shift_r <= '0;
          phase_r <= 1'b1;
        end else begin
          // single tile delta
          run_code_r <= {1'b0, byte_r[6:0]};
          acc_r      <= '0;
        end
      end
      if (cmd.fin) begin
        phase_r <= 1'b0;
        held_r  <= '0;
        acc_r   <= '0;
        shift_r <= '0;
        if (run_end) begin
          pos_r <= '0;
          fc_r  <= fc_r + 16'd1;
        end else begin
          pos_r <= pos_sum;
        end
      end
      if (cmd.key_wr && (walk_ptr_r >= fill_r)) begin
        fill_r <= walk_ptr_r + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      walk_ptr_r  <= pos_r;
      walk_left_r <= len;
    end else if (mem_we) begin
      walk_ptr_r  <= walk_ptr_r + 11'd1;
      walk_left_r <= walk_left_r - 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_cap) begin
      rec_kind_r  <= bcfs_pkg::RES_READ;
      rec_first_r <= '0;
      rec_len_r   <= '0;
      rec_code_r  <= (11'(idx_r) < fill_r) ? rdata_r : 8'h00;
      rec_key_r   <= 1'b0;
      rec_end_r   <= 1'b0;
      rec_fn_r    <= '0;
    end else if (cmd.fin) begin
      rec_kind_r  <= bcfs_pkg::RES_RUN;
      rec_first_r <= pos_r[9:0];
      rec_len_r   <= len;
      rec_code_r  <= run_code_r;
      rec_key_r   <= key_now;
      rec_end_r   <= run_end;
      rec_fn_r    <= fc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {3'b000, rec_fn_r, rec_code_r, rec_len_r, rec_first_r};
      out_user_r <= {rec_key_r, rec_kind_r};
      out_last_r <= rec_end_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  a_pos_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r < TC)
    else $error("tile position past table end");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= TC)
    else $error("fill count past table end");

  a_key_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.key_wr |-> (walk_ptr_r <= fill_r) && (walk_ptr_r < TC))
    else $error("key run write leaves a gap in the table");

  a_delta_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.delta_wr |-> (walk_ptr_r < fill_r))
    else $error("delta run touches an unwritten tile");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result loaded over a waiting word");

endmodule

### hw/rtl/block_code_frame_stream_decoder.sv
// ---------------------------------------------------------------------------
// block_code_frame_stream_decoder
// Decodes a key/delta tile frame byte stream into a table of 8-bit tile codes
// and reports one record per completed run and one word per tile read.
// ---------------------------------------------------------------------------
// sequence: byte without result S_EXEC; tile read S_EXEC, S_RDWAIT, S_EMIT; a run
//   S_EXEC, S_FIN, S_KWALK (key) or S_DRD, S_DWR (delta, not skip) per tile, S_EMIT
// throughput: one word at a time, a new one only back in S_IDLE; the run walk
//   over the single-port-write tile table sets the cost of a run
// reset: counters and parser cleared at once; the table reads as zero through a fill
//   count, so there is no clearing pass and a word is taken right after reset
module block_code_frame_stream_decoder #(
  parameter int TILE_COUNT = bcfs_pkg::TILE_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,  // frame_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // stream_byte[7:0], tile_index[17:8]
  input  logic [1:0]  in_tuser,     // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,    // first_tile[9:0], run_length[20:10],
                                    // code_value[28:21], frame_number[44:29]
  output logic [1:0]  out_tuser,    // result_kind[0], key_frame[1]
  output logic        out_tlast     // frame_end
);

  bcfs_pkg::bcfs_cmd_t    cmd;
  bcfs_pkg::bcfs_status_t st;

  bcfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  bcfs_dp #(
    .TILE_COUNT (TILE_COUNT)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cmd         (cmd),
    .st          (st)
  );

endmodule
